// File: hw/rtl/v3a_pkg.sv
// shared command codes and control group type for the vector unit
package v3a_pkg;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_SUB    = 3'd1;
  localparam logic [2:0] CMD_SCALE  = 3'd2;
  localparam logic [2:0] CMD_NEG    = 3'd3;
  localparam logic [2:0] CMD_DOT    = 3'd4;
  localparam logic [2:0] CMD_CROSS  = 3'd5;
  localparam logic [2:0] CMD_LENGTH = 3'd6;
  localparam logic [2:0] CMD_NORM   = 3'd7;

  typedef struct packed {
    logic       vld;
    logic [2:0] cmd;
    logic       ovf;
  } v3a_ctl_t;

endpackage

// File: hw/rtl/vector3_fixed_alu.sv
// top level of the three-component fixed-point vector unit
// Signed fixed-point vector unit (WORD_BITS wide, FRAC_BITS fraction bits).
// Each request carries a command, vectors a and b and a scale factor, and
// yields one result: add, sub, scale, negate and cross return r_x/r_y/r_z;
// dot and length return scalar_out; normalize returns a/|a| in r_x/r_y/r_z.
// Out-of-range results saturate and set overflow; normalizing a zero vector
// gives zeros with zero_length set. The unit is fully pipelined and takes a
// new request every cycle while no result is held. Every request, whatever
// its command, passes the same path: the product and sum stages, WORD_BITS
// cells of the square root chain (one root bit each), WORD_BITS + FRAC_BITS
// cells of the divide chain (one quotient bit per lane each), and the output
// register. When a result waits on out_stall the whole chain holds and
// in_stall rises.
module vector3_fixed_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [WORD_BITS-1:0] a_x,
  input  logic [WORD_BITS-1:0] a_y,
  input  logic [WORD_BITS-1:0] a_z,
  input  logic [WORD_BITS-1:0] b_x,
  input  logic [WORD_BITS-1:0] b_y,
  input  logic [WORD_BITS-1:0] b_z,
  input  logic [WORD_BITS-1:0] scale_factor,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] r_x,
  output logic [WORD_BITS-1:0] r_y,
  output logic [WORD_BITS-1:0] r_z,
  output logic [WORD_BITS-1:0] scalar_out,
  output logic                 overflow,
  output logic                 zero_length
);
  import v3a_pkg::*;

  localparam int NB      = WORD_BITS + FRAC_BITS;
  localparam int SQ_SIDE = 7 * WORD_BITS + 3;
  localparam int DV_SIDE = 4 * WORD_BITS + 3;
  localparam logic [WORD_BITS-1:0] MAX_WORD = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [NB-1:0] POS_LIM = {{(FRAC_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [NB-1:0] NEG_LIM = {{FRAC_BITS{1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};

  // whole chain moves together unless a finished result is held
  logic en;
  assign en       = ~(out_valid & out_stall);
  assign in_stall = rst | ~en;

  // front end
  v3a_ctl_t                  fr_ctl;
  logic [2:0][WORD_BITS-1:0] fr_r;
  logic [WORD_BITS-1:0]      fr_sc;
  logic [2*WORD_BITS-1:0]    fr_rad;
  logic [2:0]                fr_sgn;
  logic [2:0][WORD_BITS-1:0] fr_mag;

  v3a_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .cmd     (cmd),
    .a       ({a_z, a_y, a_x}),
    .b       ({b_z, b_y, b_x}),
    .s       (scale_factor),
    .ctl_out (fr_ctl),
    .r_out   (fr_r),
    .sc_out  (fr_sc),
    .rad_out (fr_rad),
    .sgn_out (fr_sgn),
    .mag_out (fr_mag)
  );

  // square root chain: sum of squares in, floor root out
  v3a_ctl_t               sq_ctl  [WORD_BITS+1];
  logic [WORD_BITS+1:0]   sq_rem  [WORD_BITS+1];
  logic [WORD_BITS-1:0]   sq_root [WORD_BITS+1];
  logic [2*WORD_BITS-1:0] sq_rad  [WORD_BITS+1];
  logic [SQ_SIDE-1:0]     sq_side [WORD_BITS+1];

  assign sq_ctl[0]  = fr_ctl;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = fr_rad;
  assign sq_side[0] = {fr_r, fr_sc, fr_sgn, fr_mag};

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_sqrt
    v3a_sqrt_cell #(
      .WORD_BITS (WORD_BITS),
      .SIDE_BITS (SQ_SIDE)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (sq_ctl[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .rad_in   (sq_rad[g]),
      .side_in  (sq_side[g]),
      .ctl_out  (sq_ctl[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .rad_out  (sq_rad[g+1]),
      .side_out (sq_side[g+1])
    );
  end

  // unpack the side data at the end of the root chain
  logic [2:0][WORD_BITS-1:0] sq_r;
  logic [WORD_BITS-1:0]      sq_sc;
  logic [2:0]                sq_sgn;
  logic [2:0][WORD_BITS-1:0] sq_mag;

  assign {sq_r, sq_sc, sq_sgn, sq_mag} = sq_side[WORD_BITS];

  // divide chain: |a_i| << FRAC_BITS over the length, three lanes
  v3a_ctl_t                   dv_ctl  [NB+1];
  logic [WORD_BITS-1:0]       dv_len  [NB+1];
  logic [2:0][WORD_BITS-1:0]  dv_rem  [NB+1];
  logic [2:0][NB-1:0]         dv_nq   [NB+1];
  logic [DV_SIDE-1:0]         dv_side [NB+1];

  assign dv_ctl[0]  = sq_ctl[WORD_BITS];
  assign dv_len[0]  = sq_root[WORD_BITS];
  assign dv_rem[0]  = '0;
  assign dv_side[0] = {sq_r, sq_sc, sq_sgn};

  for (genvar l = 0; l < 3; l++) begin : g_num
    assign dv_nq[0][l] = {sq_mag[l], {FRAC_BITS{1'b0}}};
  end

  for (genvar g = 0; g < NB; g++) begin : g_div
    v3a_div_cell #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_BITS (DV_SIDE)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (dv_ctl[g]),
      .len_in   (dv_len[g]),
      .rem_in   (dv_rem[g]),
      .nq_in    (dv_nq[g]),
      .side_in  (dv_side[g]),
      .ctl_out  (dv_ctl[g+1]),
      .len_out  (dv_len[g+1]),
      .rem_out  (dv_rem[g+1]),
      .nq_out   (dv_nq[g+1]),
      .side_out (dv_side[g+1])
    );
  end

  // final selection: length saturation, normalize sign and zero check
  logic [2:0][WORD_BITS-1:0] tl_r;
  logic [WORD_BITS-1:0]      tl_sc;
  logic [2:0]                tl_sgn;
  logic [WORD_BITS-1:0]      tl_len;
  logic [2:0][NB-1:0]        tl_q;
  logic [2:0][WORD_BITS-1:0] fin_r;
  logic [WORD_BITS-1:0]      fin_sc;
  logic                      fin_ovf;
  logic                      fin_zl;

  assign {tl_r, tl_sc, tl_sgn} = dv_side[NB];
  assign tl_len = dv_len[NB];
  assign tl_q   = dv_nq[NB];

  always_comb begin
    fin_r   = tl_r;
    fin_sc  = tl_sc;
    fin_ovf = dv_ctl[NB].ovf;
    fin_zl  = 1'b0;
    case (dv_ctl[NB].cmd)
      CMD_LENGTH: begin
        if (tl_len[WORD_BITS-1]) begin
          fin_sc  = MAX_WORD;
          fin_ovf = 1'b1;
        end else begin
          fin_sc = tl_len;
        end
      end
      CMD_NORM: begin
        if (tl_len == '0) begin
          fin_zl = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (tl_sgn[i]) begin
              if (tl_q[i] > NEG_LIM) begin
                fin_r[i] = MIN_WORD;
                fin_ovf  = 1'b1;
              end else begin
                fin_r[i] = ~tl_q[i][WORD_BITS-1:0] + 1'b1;
              end
            end else if (tl_q[i] > POS_LIM) begin
              fin_r[i] = MAX_WORD;
              fin_ovf  = 1'b1;
            end else begin
              fin_r[i] = tl_q[i][WORD_BITS-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_ctl[NB].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x         <= fin_r[0];
      r_y         <= fin_r[1];
      r_z         <= fin_r[2];
      scalar_out  <= fin_sc;
      overflow    <= fin_ovf;
      zero_length <= fin_zl;
    end
  end

  // zero-length normalize leaves every value field clear and no overflow
  a_zero_len_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_length) |->
      (r_x == '0 && r_y == '0 && r_z == '0 && scalar_out == '0 && !overflow))
    else $error("zero-length result carries data");

  // a result is either a vector or a scalar, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (scalar_out == '0 || (r_x == '0 && r_y == '0 && r_z == '0)))
    else $error("vector and scalar result fields both set");

  // a held result keeps the chain frozen
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

endmodule

// File: hw/rtl/v3a_front.sv
// front end: operand select, products, sums and saturation
module v3a_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [2:0]                        cmd,
  input  logic [2:0][WORD_BITS-1:0]         a,
  input  logic [2:0][WORD_BITS-1:0]         b,
  input  logic [WORD_BITS-1:0]              s,
  output v3a_pkg::v3a_ctl_t                 ctl_out,
  output logic [2:0][WORD_BITS-1:0]         r_out,
  output logic [WORD_BITS-1:0]              sc_out,
  output logic [2*WORD_BITS-1:0]            rad_out,
  output logic [2:0]                        sgn_out,
  output logic [2:0][WORD_BITS-1:0]         mag_out
);
  import v3a_pkg::*;

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXW = {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] MINW = {{(SW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  function automatic logic [WORD_BITS:0] sat(input logic signed [SW-1:0] v);
    logic [WORD_BITS:0] res;
    if (v > MAXW) begin
      res = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (v < MINW) begin
      res = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, v[WORD_BITS-1:0]};
    end
    return res;
  endfunction

  logic signed [WORD_BITS-1:0] ma [3];
  logic signed [WORD_BITS-1:0] mb [3];
  logic signed [WORD_BITS-1:0] mc [3];
  logic signed [WORD_BITS-1:0] md [3];

  // operand select: cross uses rotated lanes, scale takes s, length and normalize square a
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = a[i];
      mb[i] = b[i];
      mc[i] = b[(i+1)%3];
      md[i] = a[(i+2)%3];
      case (cmd) inside
        CMD_SCALE: begin
          mb[i] = s;
        end
        CMD_CROSS: begin
          ma[i] = a[(i+1)%3];
          mb[i] = b[(i+2)%3];
        end
        CMD_LENGTH, CMD_NORM: begin
          mb[i] = a[i];
        end
        default: begin
        end
      endcase
    end
  end

  // product stage
  logic                        vld1;
  logic [2:0]                  cmd1;
  logic signed [PW-1:0]        p [3];
  logic signed [PW-1:0]        q [3];
  logic signed [WORD_BITS-1:0] a1 [3];
  logic signed [WORD_BITS-1:0] b1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= cmd;
      for (int i = 0; i < 3; i++) begin
        p[i]  <= ma[i] * mb[i];
        q[i]  <= mc[i] * md[i];
        a1[i] <= a[i];
        b1[i] <= b[i];
      end
    end
  end

  // sum and saturate stage
  logic signed [SW-1:0]        lane [3];
  logic signed [SW-1:0]        dsum;
  logic signed [SW-1:0]        dshift;
  logic [WORD_BITS:0]          lsat [3];
  logic [WORD_BITS:0]          dsat;

  always_comb begin
    dsum   = SW'(p[0]) + SW'(p[1]) + SW'(p[2]);
    dshift = dsum >>> FRAC_BITS;
    dsat   = sat(dshift);
    for (int i = 0; i < 3; i++) begin
      case (cmd1)
        CMD_ADD:   lane[i] = SW'(a1[i]) + SW'(b1[i]);
        CMD_SUB:   lane[i] = SW'(a1[i]) - SW'(b1[i]);
        CMD_NEG:   lane[i] = -SW'(a1[i]);
        CMD_SCALE: lane[i] = SW'(p[i]) >>> FRAC_BITS;
        CMD_CROSS: lane[i] = (SW'(p[i]) - SW'(q[i])) >>> FRAC_BITS;
        default:   lane[i] = '0;
      endcase
      lsat[i] = sat(lane[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out.vld <= vld1;
      ctl_out.cmd <= cmd1;
      ctl_out.ovf <= lsat[0][WORD_BITS] | lsat[1][WORD_BITS] | lsat[2][WORD_BITS]
                   | ((cmd1 == CMD_DOT) & dsat[WORD_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_out  <= (cmd1 == CMD_DOT) ? dsat[WORD_BITS-1:0] : '0;
      rad_out <= dsum[PW-1:0];
      for (int i = 0; i < 3; i++) begin
        r_out[i]   <= lsat[i][WORD_BITS-1:0];
        sgn_out[i] <= a1[i][WORD_BITS-1];
        mag_out[i] <= a1[i][WORD_BITS-1] ? (~a1[i] + 1'b1) : a1[i];
      end
    end
  end

endmodule

// File: hw/rtl/v3a_sqrt_cell.sv
// one root bit of the square root chain
module v3a_sqrt_cell #(
  parameter int WORD_BITS = 32,
  parameter int SIDE_BITS = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  v3a_pkg::v3a_ctl_t        ctl_in,
  input  logic [WORD_BITS+1:0]     rem_in,
  input  logic [WORD_BITS-1:0]     root_in,
  input  logic [2*WORD_BITS-1:0]   rad_in,
  input  logic [SIDE_BITS-1:0]     side_in,
  output v3a_pkg::v3a_ctl_t        ctl_out,
  output logic [WORD_BITS+1:0]     rem_out,
  output logic [WORD_BITS-1:0]     root_out,
  output logic [2*WORD_BITS-1:0]   rad_out,
  output logic [SIDE_BITS-1:0]     side_out
);
  import v3a_pkg::*;

  logic [WORD_BITS+3:0] cur;
  logic [WORD_BITS+3:0] trial;
  logic [WORD_BITS+3:0] diff;
  logic                 take;

  assign cur   = {rem_in, rad_in[2*WORD_BITS-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign take  = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? diff[WORD_BITS+1:0] : cur[WORD_BITS+1:0];
      root_out <= {root_in[WORD_BITS-2:0], take};
      rad_out  <= {rad_in[2*WORD_BITS-3:0], 2'b00};
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/v3a_div_cell.sv
// one quotient bit of the three-lane divide chain
module v3a_div_cell #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  v3a_pkg::v3a_ctl_t                      ctl_in,
  input  logic [WORD_BITS-1:0]                   len_in,
  input  logic [2:0][WORD_BITS-1:0]              rem_in,
  input  logic [2:0][WORD_BITS+FRAC_BITS-1:0]    nq_in,
  input  logic [SIDE_BITS-1:0]                   side_in,
  output v3a_pkg::v3a_ctl_t                      ctl_out,
  output logic [WORD_BITS-1:0]                   len_out,
  output logic [2:0][WORD_BITS-1:0]              rem_out,
  output logic [2:0][WORD_BITS+FRAC_BITS-1:0]    nq_out,
  output logic [SIDE_BITS-1:0]                   side_out
);
  import v3a_pkg::*;

  localparam int NB = WORD_BITS + FRAC_BITS;

  logic [WORD_BITS:0] cur  [3];
  logic [WORD_BITS:0] diff [3];
  logic [2:0]         take;

  // numerator shifts out the top while quotient bits shift in below
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i]  = {rem_in[i], nq_in[i][NB-1]};
      take[i] = (cur[i] >= {1'b0, len_in});
      diff[i] = cur[i] - {1'b0, len_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_out  <= len_in;
      side_out <= side_in;
      for (int i = 0; i < 3; i++) begin
        rem_out[i] <= take[i] ? diff[i][WORD_BITS-1:0] : cur[i][WORD_BITS-1:0];
        nq_out[i]  <= {nq_in[i][NB-2:0], take[i]};
      end
    end
  end

endmodule

// File: test/tb_top.sv
// testbench for the three-component fixed-point vector unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import v3a_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int PIPE_DEPTH = 2 * WB + FB + 3;
  localparam int WATCHDOG_LIMIT = 4 * (PIPE_DEPTH + 2 * 14 + 3000);
  localparam logic signed [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};

  typedef struct {
    logic [WB-1:0] x, y, z, s;
    logic          ovf, zl;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = CMD_ADD;
  logic [WB-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic [WB-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic [WB-1:0] scale_factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WB-1:0] r_x, r_y, r_z, scalar_out;
  logic overflow, zero_length;

  vec_result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int rx_wait = 0;
  int rx_draw = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  bit random_stall = 1'b0;

  always #5 clk = ~clk;

  vector3_fixed_alu #(.WORD_BITS(WB), .FRAC_BITS(FB)) uut (.*);

  // clamp a wide signed value to the word range, flagging overflow
  function automatic logic [WB-1:0] clamp(input logic signed [199:0] v, inout logic ovf);
    if (v > WMAX) begin
      ovf = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      ovf = 1'b1;
      return WMIN;
    end
    return v[WB-1:0];
  endfunction

  // integer floor square root by bit-pair restoring method
  function automatic logic [127:0] isqrt(input logic [199:0] v);
    logic [199:0] rem;
    logic [127:0] root;
    logic [199:0] trial;
    rem = '0;
    root = '0;
    for (int i = 99; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 200'd3);
      trial = ({72'd0, root} << 2) | 200'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic vec_result_t compute_vector_op(
      input logic [2:0] c, input logic [WB-1:0] ax, ay, az, bx, by, bz, sf);
    vec_result_t res;
    logic signed [199:0] a[3], b[3], s, acc, len, mg, q;
    logic ovf;
    ovf = 1'b0;
    res = '{default: '0};
    a[0] = $signed(ax); a[1] = $signed(ay); a[2] = $signed(az);
    b[0] = $signed(bx); b[1] = $signed(by); b[2] = $signed(bz);
    s = $signed(sf);
    case (c)
      CMD_ADD, CMD_SUB, CMD_SCALE, CMD_NEG, CMD_CROSS, CMD_NORM: begin
        logic [WB-1:0] r[3];
        r = '{default: '0};
        if (c == CMD_NORM) begin
          len = isqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
          if (len == 0) res.zl = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
          case (c)
            CMD_ADD: r[i] = clamp(a[i] + b[i], ovf);
            CMD_SUB: r[i] = clamp(a[i] - b[i], ovf);
            CMD_SCALE: r[i] = clamp((a[i] * s) >>> FB, ovf);
            CMD_NEG: r[i] = clamp(-a[i], ovf);
            CMD_CROSS:
              r[i] = clamp((a[(i+1)%3] * b[(i+2)%3] - b[(i+1)%3] * a[(i+2)%3]) >>> FB, ovf);
            default: begin
              if (!res.zl) begin
                // divide the magnitude, truncating toward zero, then restore sign
                mg = (a[i] < 0) ? -a[i] : a[i];
                q = (mg <<< FB) / len;
                r[i] = clamp((a[i] < 0) ? -q : q, ovf);
              end
            end
          endcase
        end
        res.x = r[0]; res.y = r[1]; res.z = r[2];
      end
      CMD_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        res.s = clamp(acc >>> FB, ovf);
      end
      default: begin
        len = isqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        res.s = clamp(len, ovf);
      end
    endcase
    res.ovf = ovf;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WB-1:0] got, want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // send one request after a random gap, holding it until accepted
  // called at a rising edge; valid stays up so requests can follow back to back
  task automatic send_request(input logic [2:0] c, input logic [WB-1:0] ax, ay, az,
                              bx, by, bz, sf, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13));
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    scale_factor <= sf;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(compute_vector_op(c, ax, ay, az, bx, by, bz, sf));
  endtask

  function automatic logic [WB-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? {16'd0, 16'd0} + ($urandom & 32'h3_ffff)
                                     : -($urandom & 32'h3_ffff);
      4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  // receiver side: a drawn wait after each result plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off <= 3 * PIPE_DEPTH;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else if (random_stall && out_valid && !out_stall) begin
      rx_draw = $urandom_range(0, 13);
      rx_wait <= (rx_draw > 0) ? rx_draw - 1 : 0;
      out_stall <= (rx_draw > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", r_x, '0);
      end else begin
        vec_result_t e;
        e = expected_results.pop_front();
        if (r_x !== e.x) report_mismatch("r_x", r_x, e.x);
        if (r_y !== e.y) report_mismatch("r_y", r_y, e.y);
        if (r_z !== e.z) report_mismatch("r_z", r_z, e.z);
        if (scalar_out !== e.s) report_mismatch("scalar_out", scalar_out, e.s);
        if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
        if (zero_length !== e.zl) report_mismatch("zero_length", zero_length, e.zl);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    // extremes, every command, zero and tiny normalize
    for (int c = 0; c < 8; c++)
      send_request(c[2:0], WMAX, WMIN, 32'h0001_8000, WMIN, WMAX, 32'hfffe_0000, WMIN);
    send_request(CMD_NEG, WMIN, WMAX, '0, '0, '0, '0, '0);
    send_request(CMD_NORM, '0, '0, '0, WMAX, WMAX, WMAX, WMAX);
    send_request(CMD_NORM, 32'd1, '0, '0, '0, '0, '0, '0);
    send_request(CMD_NORM, '0, '0, 32'hffff_ffff, '0, '0, '0, '0);
    send_request(CMD_LENGTH, WMIN, WMIN, WMIN, '0, '0, '0, '0);
    send_request(CMD_LENGTH, '0, '0, '0, '0, '0, '0, '0);
    send_request(CMD_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, '0);
    send_request(CMD_DOT, 32'hffff_ffff, '0, '0, 32'd1, '0, '0, '0);
    send_request(CMD_SCALE, 32'hffff_ffff, 32'd1, WMAX, '0, '0, '0, 32'd1);
    send_request(CMD_SCALE, 32'h0002_0000, 32'hfffe_0000, WMAX, '0, '0, '0, 32'h0001_0000);
    send_request(CMD_CROSS, 32'h0001_0000, '0, '0, '0, 32'h0001_0000, '0, '0);
    send_request(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(input int count);
    random_stall = 1'b1;
    for (int i = 0; i < count; i++)
      send_request(3'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // fill the pipeline behind a long receiver hold-off
  task automatic test_backpressure();
    random_stall = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 2 * PIPE_DEPTH; i++)
      send_request(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, 1'b1);
    random_stall = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(350);
    test_backpressure();
    test_random(230);
    in_valid <= 1'b0;
    random_stall = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: vector3_fixed_alu.f
hw/rtl/v3a_pkg.sv
hw/rtl/v3a_front.sv
hw/rtl/v3a_sqrt_cell.sv
hw/rtl/v3a_div_cell.sv
hw/rtl/vector3_fixed_alu.sv
test/tb_top.sv
